[rtl/lgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared operation codes and life-rule constants for the life grid block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // operation codes carried on the input and echoed on the result beat
    typedef logic [1:0] op_t;
    localparam op_t OP_WRITE   = 2'd0;
    localparam op_t OP_READ    = 2'd1;
    localparam op_t OP_ADVANCE = 2'd2;

    // neighbor count width and the B3/S23 counts
    localparam int NBR_W = 4;
    typedef logic [NBR_W-1:0] nbr_cnt_t;
    localparam nbr_cnt_t BIRTH_COUNT   = 4'd3;
    localparam nbr_cnt_t SURVIVE_COUNT = 4'd2;

endpackage

[rtl/life_grid_generation_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Conway life grid (B3/S23, dead edges) with cell write, cell read and
// one-generation advance.
// ----------------------------------------------------------------------------
// The grid lives in a chain of ROWS row cells. Every operation rotates the
// chain once around, one row per cycle past a head position where the write,
// the read or the life rule is applied. An input beat is accepted in the idle
// state, the chain rotates in the run state and the result is handed over in
// the push state; the rotation runs the length of the row chain. A new input
// beat is taken in the cycle after the previous result
// has moved to the output register, even if that result beat has not been
// taken yet; while an older result still waits there, the block holds in the
// handover cycle and the input stays closed. Reset clears every cell to dead.
// ----------------------------------------------------------------------------
module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [4:0] s_row,
    input  logic [4:0] s_col,
    input  logic       s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_alive,
    output logic [1:0] m_done_op
);

    localparam int CW = $clog2(ROWS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PUSH
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    op_t             op_reg;
    logic [4:0]      row_reg;
    logic [4:0]      col_reg;
    logic            value_reg;
    logic [COLS-1:0] prior_reg;
    logic            alive_reg;
    logic            m_valid_reg;
    logic            m_alive_reg;
    op_t             m_done_op_reg;

    logic [COLS-1:0] rows_q [ROWS];
    logic [COLS-1:0] head;
    logic [COLS-1:0] below;
    logic [COLS-1:0] life_row;
    logic [COLS-1:0] head_new;
    logic [COLS-1:0] bit_mask;
    logic            head_bit;
    logic            hit;
    logic            last;
    logic            shift_en;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_alive   = m_alive_reg;
    assign m_done_op = m_done_op_reg;
    assign shift_en  = (state_reg == S_RUN);

    // row chain: cell k takes cell k+1, the last cell takes the processed head
    for (genvar k = 0; k < ROWS; k++) begin : g_cell
        logic [COLS-1:0] d_in;
        if (k == ROWS - 1) begin : g_tail
            assign d_in = head_new;
        end else begin : g_link
            assign d_in = rows_q[k+1];
        end
        lgs_row_cell #(
            .COLS(COLS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift_en(shift_en),
            .d_in    (d_in),
            .q       (rows_q[k])
        );
    end

    // head window; on the last row the cell behind already holds new row 0
    assign head  = rows_q[0];
    assign last  = (cnt_reg == CW'(ROWS - 1));
    assign below = last ? '0 : rows_q[1];

    lgs_life_rule #(
        .COLS(COLS)
    ) u_rule (
        .above   (prior_reg),
        .here    (head),
        .below   (below),
        .next_row(life_row)
    );

    // head row update; a column past the edge shifts the mask out to zero
    always_comb begin
        hit      = (int'(cnt_reg) == int'(row_reg));
        bit_mask = {{(COLS-1){1'b0}}, 1'b1} << col_reg;
        head_bit = |(head & bit_mask);
        case (op_reg)
            OP_WRITE: begin
                if (hit) begin
                    head_new = value_reg ? (head | bit_mask) : (head & ~bit_mask);
                end else begin
                    head_new = head;
                end
            end
            OP_ADVANCE: head_new = life_row;
            default:    head_new = head;
        endcase
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            prior_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_PUSH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_operation;
                        row_reg   <= s_row;
                        col_reg   <= s_col;
                        value_reg <= s_value;
                        alive_reg <= 1'b0;
                        prior_reg <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    prior_reg <= head;
                    if ((op_reg == OP_READ) && hit) begin
                        alive_reg <= head_bit;
                    end
                    if (last) begin
                        cnt_reg   <= '0;
                        state_reg <= S_PUSH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_alive_reg   <= alive_reg;
                        m_done_op_reg <= op_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // an accepted beat keeps the input closed while the chain rotates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again during a rotation");

    // only a read reports a live cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_done_op != OP_READ)) |-> !m_alive)
        else $error("alive set on a non-read result");

    // chain is aligned (row 0 at the head) whenever the block is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (cnt_reg == '0))
        else $error("row chain not aligned while idle");

    // a result is loaded only when leaving the handover state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH && (!m_valid || m_ready)) |=> (m_valid && s_ready))
        else $error("result handover failed");

endmodule

[rtl/lgs_row_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_row_cell
// One link of the row chain: holds one grid row and takes the row of its
// neighbor whenever the chain rotates.
// ----------------------------------------------------------------------------
module lgs_row_cell #(
    parameter int COLS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  logic [COLS-1:0] d_in,
    output logic [COLS-1:0] q
);

    logic [COLS-1:0] row_reg;
    logic [COLS-1:0] row_next;

    // take the neighbor's row on a rotate step
    always_comb begin
        row_next = shift_en ? d_in : row_reg;
    end

    // grid is cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    assign q = row_reg;

endmodule

[rtl/lgs_life_rule.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_life_rule
// Next state of one row from the old rows above, here and below (B3/S23,
// cells past the edges count as dead).
// ----------------------------------------------------------------------------
module lgs_life_rule
    import lgs_pkg::*;
#(
    parameter int COLS = 32
) (
    input  logic [COLS-1:0] above,
    input  logic [COLS-1:0] here,
    input  logic [COLS-1:0] below,
    output logic [COLS-1:0] next_row
);

    // per-column neighbor count, columns are independent
    always_comb begin
        logic [COLS+1:0] a_p;
        logic [COLS+1:0] h_p;
        logic [COLS+1:0] b_p;
        nbr_cnt_t        n;
        a_p = {1'b0, above, 1'b0};
        h_p = {1'b0, here, 1'b0};
        b_p = {1'b0, below, 1'b0};
        n   = '0;
        for (int c = 0; c < COLS; c++) begin
            n = {3'b000, a_p[c]} + {3'b000, a_p[c+1]} + {3'b000, a_p[c+2]}
              + {3'b000, h_p[c]} + {3'b000, h_p[c+2]}
              + {3'b000, b_p[c]} + {3'b000, b_p[c+1]} + {3'b000, b_p[c+2]};
            next_row[c] = (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && h_p[c+1]);
        end
    end

endmodule
